>>> src/trapezoid_sweep_generator_assert.svh
// Assertion macros used by the trapezoid sweep generator controller
`ifndef TRAPEZOID_SWEEP_GENERATOR_ASSERT_SVH
`define TRAPEZOID_SWEEP_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define TSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsg assertion failed");

// Next-cycle implication, disabled while reset is high
`define TSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsg assertion failed");

`endif

>>> src/tsg_pkg.sv
// Shared constants and control types of the trapezoid sweep generator
package tsg_pkg;

   // default field widths
   localparam int DEF_TIME_BITS  = 24;
   localparam int DEF_ANGLE_BITS = 16;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_ANGLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_ANGLE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_TICKS  = 2'd3;

   // sweep phase codes
   localparam logic [1:0] PHASE_HOLD_START = 2'd0;
   localparam logic [1:0] PHASE_RAMP_UP    = 2'd1;
   localparam logic [1:0] PHASE_HOLD_END   = 2'd2;
   localparam logic [1:0] PHASE_RAMP_BACK  = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic start;     // latch timer + elapsed into the divider
      logic step;      // one shift-subtract step
      logic sel_ramp;  // divisor is ramp_ticks, else the period
      logic classify;  // decode phase, update timer
      logic mul_load;  // register |d| * offset
      logic div_load;  // seed the divider with the product
      logic finish;    // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic period_zero;
      logic need_div;
   } sts_type;

endpackage

>>> src/tsg_req_if.sv
// Request channel: elapsed-time transactions
interface tsg_req_if import tsg_pkg::*; #(
   parameter int TIME_BITS = DEF_TIME_BITS
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] elapsed;

   modport source (output valid, output elapsed, input ready);
   modport sink   (input valid, input elapsed, output ready);
endinterface

>>> src/tsg_rsp_if.sv
// Response channel: angle and phase transactions
interface tsg_rsp_if import tsg_pkg::*; #(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle;
   logic [1:0]                   phase;

   modport source (output valid, output angle, output phase, input ready);
   modport sink   (input valid, input angle, input phase, output ready);
endinterface

>>> src/tsg_datapath.sv
// Datapath: config registers, phase timer, shared shift-subtract divider, output register
module tsg_datapath import tsg_pkg::*; #(
   parameter int TIME_BITS  = DEF_TIME_BITS,
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cmd_type                             cmd,
   output sts_type                             sts,
   input  logic [TIME_BITS-1:0]                elapsed,
   input  logic                                csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [((TIME_BITS > ANGLE_BITS) ? TIME_BITS : ANGLE_BITS)-1:0] csr_wdata,
   output logic signed [ANGLE_BITS-1:0]        angle,
   output logic [1:0]                          phase
);
   localparam int SUM_W = TIME_BITS + 3;
   localparam int RW    = TIME_BITS + 2;
   localparam int SW    = (SUM_W > ANGLE_BITS) ? SUM_W : ANGLE_BITS;
   localparam int PW    = TIME_BITS + ANGLE_BITS;

   // configuration
   logic [ANGLE_BITS-1:0] start_ff, end_ff;
   logic [TIME_BITS-1:0]  ramp_ff, hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         ramp_ff  <= '0;
         hold_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_START_ANGLE: start_ff <= csr_wdata[ANGLE_BITS-1:0];
            REG_END_ANGLE:   end_ff   <= csr_wdata[ANGLE_BITS-1:0];
            REG_RAMP_TICKS:  ramp_ff  <= csr_wdata[TIME_BITS-1:0];
            REG_HOLD_TICKS:  hold_ff  <= csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // period and its partial sums
   logic [RW-1:0] hold_ramp, hold2_ramp, period;
   logic          period_zero;
   assign hold_ramp   = RW'(hold_ff) + RW'(ramp_ff);
   assign hold2_ramp  = hold_ramp + RW'(hold_ff);
   assign period      = {hold_ramp[RW-2:0], 1'b0};
   assign period_zero = (ramp_ff == '0) && (hold_ff == '0);

   // shared restoring divider
   logic [RW-1:0]    rem_ff, rem_in;
   logic [SW-1:0]    shift_ff, shift_in;
   logic [RW-1:0]    timer_ff, timer_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [RW:0]      cand, divisor, diff;
   logic             take;
   logic [SUM_W-1:0] sum;

   assign sum     = SUM_W'(timer_ff) + SUM_W'(elapsed);
   assign cand    = {rem_ff, shift_ff[SW-1]};
   assign divisor = cmd.sel_ramp ? (RW+1)'(ramp_ff) : (RW+1)'(period);
   assign diff    = cand - divisor;
   assign take    = (cand >= divisor);

   // phase decode on the reduced timer
   logic [1:0]           phase_cls;
   logic [TIME_BITS-1:0] off_cls;
   logic                 need_div_cls;
   logic [RW-1:0]        t_minus_h, t_minus_h2r;

   assign t_minus_h   = rem_ff - RW'(hold_ff);
   assign t_minus_h2r = rem_ff - hold2_ramp;

   always_comb begin
      phase_cls    = PHASE_HOLD_START;
      off_cls      = '0;
      need_div_cls = 1'b0;
      if (period_zero) begin
         phase_cls = PHASE_HOLD_START;
      end else if (rem_ff < RW'(hold_ff)) begin
         phase_cls = PHASE_HOLD_START;
      end else if (rem_ff < hold_ramp) begin
         phase_cls    = PHASE_RAMP_UP;
         off_cls      = t_minus_h[TIME_BITS-1:0];
         need_div_cls = 1'b1;
      end else if (rem_ff < hold2_ramp) begin
         phase_cls = PHASE_HOLD_END;
      end else begin
         phase_cls    = PHASE_RAMP_BACK;
         off_cls      = t_minus_h2r[TIME_BITS-1:0];
         need_div_cls = (ramp_ff != '0);
      end
   end

   assign sts = '{period_zero: period_zero, need_div: need_div_cls};

   // angle difference, magnitude and sign
   logic signed [ANGLE_BITS:0] delta;
   logic [ANGLE_BITS:0]        delta_abs;
   logic                       neg;
   assign delta     = $signed({end_ff[ANGLE_BITS-1], end_ff})
                    - $signed({start_ff[ANGLE_BITS-1], start_ff});
   assign neg       = delta[ANGLE_BITS];
   assign delta_abs = neg ? (~delta + 1'b1) : delta;

   // full-width product of |d| and the ramp offset
   assign prod_in = delta_abs[ANGLE_BITS-1:0] * off_ff;

   // divider and timer registers
   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      timer_in = timer_ff;
      if (cmd.start) begin
         rem_in   = '0;
         shift_in = SW'(sum) << (SW - SUM_W);
      end else if (cmd.step) begin
         rem_in   = take ? diff[RW-1:0] : cand[RW-1:0];
         shift_in = {shift_ff[SW-2:0], take};
      end else if (cmd.div_load) begin
         rem_in   = RW'(prod_ff[PW-1:ANGLE_BITS]);
         shift_in = SW'(prod_ff[ANGLE_BITS-1:0]) << (SW - ANGLE_BITS);
      end
      if (cmd.classify) begin
         timer_in = period_zero ? '0 : rem_ff;
      end
   end

   logic [1:0]           phase_ff;
   logic [TIME_BITS-1:0] off_ff;
   logic                 need_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
      end else begin
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (cmd.classify) begin
         phase_ff    <= phase_cls;
         off_ff      <= off_cls;
         need_div_ff <= need_div_cls;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
   end

   // final angle from the quotient
   logic [ANGLE_BITS+1:0]  q_ext, sq, a0_ext, a1_ext, up_ang, back_ang;
   logic [ANGLE_BITS-1:0]  angle_in;

   assign q_ext    = (ANGLE_BITS+2)'(shift_ff[ANGLE_BITS-1:0]);
   assign sq       = neg ? (~q_ext + 1'b1) : q_ext;
   assign a0_ext   = {{2{start_ff[ANGLE_BITS-1]}}, start_ff};
   assign a1_ext   = {{2{end_ff[ANGLE_BITS-1]}}, end_ff};
   assign up_ang   = a0_ext + sq;
   assign back_ang = a1_ext - sq;

   always_comb begin
      case (phase_ff)
         PHASE_HOLD_START: angle_in = start_ff;
         PHASE_RAMP_UP:    angle_in = up_ang[ANGLE_BITS-1:0];
         PHASE_HOLD_END:   angle_in = end_ff;
         PHASE_RAMP_BACK:  angle_in = need_div_ff ? back_ang[ANGLE_BITS-1:0] : start_ff;
         default:          angle_in = start_ff;
      endcase
   end

   // result register
   logic [ANGLE_BITS-1:0] angle_ff;
   logic [1:0]            phase_out_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         angle_ff     <= angle_in;
         phase_out_ff <= phase_ff;
      end
   end

   assign angle = $signed(angle_ff);
   assign phase = phase_out_ff;

endmodule

>>> src/tsg_controller.sv
// Controller: runs modulo (nonzero period), phase decode, ramp multiply and divide
`include "trapezoid_sweep_generator_assert.svh"

module tsg_controller import tsg_pkg::*; #(
   parameter int TIME_BITS  = DEF_TIME_BITS,
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam int SUM_W = TIME_BITS + 3;
   localparam int SW    = (SUM_W > ANGLE_BITS) ? SUM_W : ANGLE_BITS;
   localparam int CW    = $clog2(SW + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MOD   = 3'd1;
   localparam logic [2:0] ST_CLASS = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DLOAD = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = CW'(SUM_W);
               state_in  = sts.period_zero ? ST_CLASS : ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            state_in     = sts.need_div ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = CW'(ANGLE_BITS);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.step     = 1'b1;
            cmd.sel_ramp = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on finish, cleared when the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TSG_ASSERT_NEXT(a_zero_period_skips_mod, clock, reset, (req_valid && req_ready && sts.period_zero), (state_ff == ST_CLASS))
   `TSG_ASSERT_NOW(a_count_live, clock, reset, (state_ff == ST_MOD || state_ff == ST_DIV), (cnt_ff != '0))
   `TSG_ASSERT_NEXT(a_fin_waits, clock, reset, (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready), (state_ff == ST_FIN && rsp_valid_ff))

endmodule

>>> src/trapezoid_sweep_generator.sv
// Trapezoid sweep generator: each accepted request runs the bit-serial modulo of the timer
// (skipped for a zero period), then phase decode; a ramp phase adds the multiply and the
// bit-serial ramp divide before the result is registered and response valid is set.
// One transaction at a time, the next accepted the cycle after finish; a response not yet
// taken holds off finish.
// Synchronous active-high reset clears config registers, phase timer and control state.
module trapezoid_sweep_generator import tsg_pkg::*; #(
   parameter int TIME_BITS  = DEF_TIME_BITS,
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   tsg_req_if.sink                   req_chan,
   tsg_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((TIME_BITS > ANGLE_BITS) ? TIME_BITS : ANGLE_BITS)-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   tsg_controller #(
      .TIME_BITS  (TIME_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsg_datapath #(
      .TIME_BITS  (TIME_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .elapsed      (req_chan.elapsed),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .angle        (rsp_chan.angle),
      .phase        (rsp_chan.phase)
   );

endmodule
